/* hdl/wsft_pkg.sv */
package wsft_pkg;

	localparam int PAGE_W   = 8;
	localparam int WIN_W    = 9;
	localparam int FTOT_W   = 32;
	localparam int STOT_W   = 40;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [WIN_W-1:0]  win_t;
	typedef logic [FTOT_W-1:0] ftot_t;
	typedef logic [STOT_W-1:0] stot_t;

	// Data handed from one cell to the next older one on every transfer.
	typedef struct packed {
		page_t page;
		logic  valid;
		logic  dup;
	} cell_link_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		page_t pg;
		logic  shift;
		logic  restart;
		logic  load;
		win_t  win;
	} cell_ctrl_t;

	// What each cell reports back for the current reference.
	typedef struct packed {
		logic hit_win;
		logic hit_rem;
		logic drop;
	} cell_stat_t;

endpackage

/* hdl/wsft_ifs.sv */
interface wsft_in_if;
	logic              valid;
	logic              ready;
	wsft_pkg::page_t   page;
	logic              new_run;

	modport source (output valid, output page, output new_run, input ready);
	modport sink (input valid, input page, input new_run, output ready);
endinterface

interface wsft_out_if;
	logic              valid;
	logic              ready;
	logic              fault;
	wsft_pkg::win_t    set_size;
	wsft_pkg::ftot_t   fault_total;
	wsft_pkg::stot_t   size_total;

	modport source (output valid, output fault, output set_size, output fault_total,
		output size_total, input ready);
	modport sink (input valid, input fault, input set_size, input fault_total,
		input size_total, output ready);
endinterface

/* hdl/wsft_cell.sv */
module wsft_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wsft_pkg::cell_ctrl_t ctrl,
	input  wsft_pkg::cell_link_t lnk_in,
	output wsft_pkg::cell_link_t lnk_out,
	output wsft_pkg::cell_stat_t stat
);
	import wsft_pkg::*;

	page_t page_q;
	logic  valid_q;
	logic  dup_q;
	logic  in_win_q;
	logic  in_rem_q;
	logic  tail_q;
	logic  match;

	assign match = valid_q && (page_q == ctrl.pg) && !ctrl.restart;

	// A newer reference to the same page marks this entry as a duplicate as it moves on.
	assign lnk_out.page  = page_q;
	assign lnk_out.valid = valid_q;
	assign lnk_out.dup   = dup_q || match;

	assign stat.hit_win = match && in_win_q;
	assign stat.hit_rem = match && in_rem_q;
	assign stat.drop    = tail_q && valid_q && !dup_q && !ctrl.restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			dup_q    <= 1'b0;
			in_win_q <= (IDX < 1);
			in_rem_q <= 1'b0;
			tail_q   <= (IDX == 0);
		end else if (ctrl.load) begin
			valid_q  <= 1'b0;
			dup_q    <= 1'b0;
			in_win_q <= (IDX < int'(ctrl.win));
			in_rem_q <= (IDX + 1 < int'(ctrl.win));
			tail_q   <= (IDX + 1 == int'(ctrl.win));
		end else if (ctrl.shift) begin
			// The first cell always keeps the new reference, even when it starts a new run.
			valid_q <= lnk_in.valid && (!ctrl.restart || (IDX == 0));
			dup_q   <= lnk_in.dup;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			page_q <= lnk_in.page;
		end
	end

endmodule

/* hdl/working_set_fault_tracker.sv */
// Working set fault tracker. One page reference is taken per transfer and one result is
// returned for it; a new reference can be taken in every cycle, including the cycle in which
// the previous result is taken, so while results are taken the rate is one reference per
// cycle, each result registered in the cycle after its reference. Each history cell compares
// its stored page against the incoming reference in the same cycle, and the reported hits
// update the distinct-page count and the saturating totals before the history shifts by one
// cell. A write to window_size takes effect at once and empties the window (the totals are
// kept); it needs no clearing pass, and writes are meant to happen only while no result is
// outstanding. A window size of zero acts as one, and one above WINDOW_MAX acts as WINDOW_MAX.
module working_set_fault_tracker #(
	parameter int WINDOW_MAX = 256,
	parameter int PAGE_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	wsft_in_if.sink             refs,
	wsft_out_if.source          results,
	input  logic                cfg_we,
	input  wsft_pkg::win_t      cfg_wdata
);
	import wsft_pkg::*;

	function automatic page_t reduce_page(input page_t p);
		int r;
		r = int'(p);
		for (int k = PAGE_W - 1; k >= 0; k--) begin
			if (r >= (PAGE_COUNT << k)) begin
				r = r - (PAGE_COUNT << k);
			end
		end
		return page_t'(r);
	endfunction

	function automatic win_t eff_window(input win_t w);
		if (w == '0) begin
			return win_t'(1);
		end else if (int'(w) > WINDOW_MAX) begin
			return win_t'(WINDOW_MAX);
		end
		return w;
	endfunction

	cell_ctrl_t ctrl;
	cell_link_t head;
	cell_link_t lnk [WINDOW_MAX];
	cell_stat_t stat [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] hit_win_v;
	logic [WINDOW_MAX-1:0] hit_rem_v;
	logic [WINDOW_MAX-1:0] drop_v;

	logic  acc;
	logic  fault_n;
	logic  add;
	logic  drop;
	win_t  dist_base;
	win_t  dist_n;
	ftot_t ftot_base;
	ftot_t ftot_n;
	stot_t stot_base;
	logic [STOT_W:0] stot_sum;

	logic  out_valid_q;
	logic  fault_q;
	win_t  dist_q;
	ftot_t ftot_q;
	stot_t stot_q;
	win_t  win_q;

	assign refs.ready = !out_valid_q || results.ready;
	assign acc        = refs.valid && refs.ready;

	assign ctrl.pg      = reduce_page(refs.page);
	assign ctrl.shift   = acc;
	assign ctrl.restart = refs.new_run;
	assign ctrl.load    = cfg_we;
	assign ctrl.win     = eff_window(cfg_wdata);

	assign head.page  = ctrl.pg;
	assign head.valid = 1'b1;
	assign head.dup   = 1'b0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_first
			wsft_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.lnk_in  (head),
				.lnk_out (lnk[i]),
				.stat    (stat[i])
			);
		end else begin : g_rest
			wsft_cell #(.IDX(i)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.lnk_in  (lnk[i-1]),
				.lnk_out (lnk[i]),
				.stat    (stat[i])
			);
		end
		assign hit_win_v[i] = stat[i].hit_win;
		assign hit_rem_v[i] = stat[i].hit_rem;
		assign drop_v[i]    = stat[i].drop;
	end

	// The page is new to the window if no cell inside it holds it; it adds to the set if
	// no cell that stays after the oldest one leaves holds it.
	assign fault_n = !(|hit_win_v);
	assign add     = !(|hit_rem_v);
	assign drop    = |drop_v;

	assign dist_base = refs.new_run ? '0 : dist_q;
	assign ftot_base = refs.new_run ? '0 : ftot_q;
	assign stot_base = refs.new_run ? '0 : stot_q;

	assign dist_n   = dist_base - win_t'(drop) + win_t'(add);
	assign ftot_n   = ftot_base + ftot_t'(fault_n && (ftot_base != '1));
	assign stot_sum = {1'b0, stot_base} + (STOT_W+1)'(dist_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dist_q      <= '0;
			ftot_q      <= '0;
			stot_q      <= '0;
			win_q       <= win_t'(1);
		end else begin
			if (cfg_we) begin
				dist_q <= '0;
				win_q  <= ctrl.win;
			end else if (acc) begin
				dist_q <= dist_n;
				ftot_q <= ftot_n;
				stot_q <= stot_sum[STOT_W] ? '1 : stot_sum[STOT_W-1:0];
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fault_q <= fault_n;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.fault       = fault_q;
	assign results.set_size    = dist_q;
	assign results.fault_total = ftot_q;
	assign results.size_total  = stot_q;

	// The set never holds more pages than the window has references.
	a_set_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q <= win_q)
		else $error("distinct page count exceeds the window size");

	// Every result counts at least the page just referenced.
	a_set_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (dist_q != '0))
		else $error("result reports an empty working set");

	// A fault always leaves a nonzero fault total behind.
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (!fault_q || (ftot_q != '0)))
		else $error("fault not reflected in the fault total");

	// A fresh run starts the size total at the first set size.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && refs.new_run && !cfg_we) |=> (stot_q == stot_t'(dist_q)))
		else $error("size total not restarted by a new run");

endmodule
